/* hdl/hmsudt_pkg.sv */
package hmsudt_pkg;

    localparam logic [10:0] MS_PER_SECOND = 11'd1000;
    localparam logic [9:0]  MAX_ELAPSED   = 10'd999;
    localparam logic [5:0]  TOP_MINSEC    = 6'd59;
    localparam logic [6:0]  MINSEC_WRAP   = 7'd60;
    localparam logic [8:0]  HOUR_WRAP     = 9'd24;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_PAUSE = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_START_HOURS   = 2'd0,
        CFG_START_MINUTES = 2'd1,
        CFG_START_SECONDS = 2'd2,
        CFG_COUNT_DOWN    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] start_hours;
        logic [5:0] start_minutes;
        logic [5:0] start_seconds;
        logic       count_down;
    } cfg_t;

    typedef struct packed {
        logic [7:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [9:0] milli;
        logic       paused;
        logic       done;
    } timer_state_t;

endpackage

/* hdl/hmsudt_cfg_regs.sv */
module hmsudt_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output hmsudt_pkg::cfg_t     cfg
);
    import hmsudt_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_HOURS:   cfg_reg.start_hours   <= cfg_data;
                CFG_START_MINUTES: cfg_reg.start_minutes <= cfg_data[5:0];
                CFG_START_SECONDS: cfg_reg.start_seconds <= cfg_data[5:0];
                CFG_COUNT_DOWN:    cfg_reg.count_down    <= cfg_data[0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/hmsudt_step.sv */
module hmsudt_step (
    input  hmsudt_pkg::cfg_t         cfg,
    input  hmsudt_pkg::timer_state_t cur,
    input  hmsudt_pkg::req_t         req,
    input  logic [9:0]               elapsed_ms,
    output hmsudt_pkg::timer_state_t nxt
);
    import hmsudt_pkg::*;

    timer_state_t stepped;
    logic [6:0]   sec_inc;
    logic [6:0]   min_inc;
    logic [8:0]   hr_inc;
    logic [9:0]   ms_clamp;
    logic [10:0]  sum;

    // one second forward or back
    always_comb
    begin
        stepped = cur;
        sec_inc = {1'b0, cur.seconds} + 7'd1;
        min_inc = {1'b0, cur.minutes};
        hr_inc  = {1'b0, cur.hours};
        if (cfg.count_down)
        begin
            if (cur.seconds != 6'd0)
            begin
                stepped.seconds = cur.seconds - 6'd1;
            end
            else if (cur.minutes != 6'd0)
            begin
                stepped.minutes = cur.minutes - 6'd1;
                stepped.seconds = TOP_MINSEC;
            end
            else if (cur.hours != 8'd0)
            begin
                stepped.hours   = cur.hours - 8'd1;
                stepped.minutes = TOP_MINSEC;
                stepped.seconds = TOP_MINSEC;
            end
            if (stepped.hours == 8'd0 && stepped.minutes == 6'd0
                && stepped.seconds == 6'd0)
            begin
                stepped.done = 1'b1;
            end
        end
        else
        begin
            if (sec_inc >= MINSEC_WRAP)
            begin
                stepped.seconds = 6'd0;
                min_inc = {1'b0, cur.minutes} + 7'd1;
            end
            else
            begin
                stepped.seconds = sec_inc[5:0];
            end
            if (min_inc >= MINSEC_WRAP)
            begin
                stepped.minutes = 6'd0;
                hr_inc = {1'b0, cur.hours} + 9'd1;
            end
            else
            begin
                stepped.minutes = min_inc[5:0];
            end
            stepped.hours = (hr_inc >= HOUR_WRAP) ? 8'd0 : hr_inc[7:0];
        end
    end

    always_comb
    begin
        nxt      = cur;
        ms_clamp = (elapsed_ms > MAX_ELAPSED) ? MAX_ELAPSED : elapsed_ms;
        sum      = {1'b0, cur.milli} + {1'b0, ms_clamp};
        unique case (req)
            REQ_LOAD:
            begin
                nxt.hours   = cfg.start_hours;
                nxt.minutes = (cfg.start_minutes > TOP_MINSEC) ? TOP_MINSEC
                                                               : cfg.start_minutes;
                nxt.seconds = (cfg.start_seconds > TOP_MINSEC) ? TOP_MINSEC
                                                               : cfg.start_seconds;
                nxt.milli   = 10'd0;
                nxt.paused  = 1'b0;
                nxt.done    = 1'b0;
            end
            REQ_TICK:
            begin
                if (!cur.paused && !cur.done)
                begin
                    if (sum >= MS_PER_SECOND)
                    begin
                        nxt       = stepped;
                        nxt.milli = 10'(sum - MS_PER_SECOND);
                    end
                    else
                    begin
                        nxt.milli = sum[9:0];
                    end
                end
            end
            REQ_PAUSE:
            begin
                nxt.paused = ~cur.paused;
            end
            REQ_NONE:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* hdl/hms_up_down_timer_core.sv */
// hours:minutes:seconds timer, counting down to zero or up with 24-hour wrap
//
// configuration: cfg_valid/cfg_ready with cfg_index (0 start hours, 1 start
// minutes, 2 start seconds, 3 count_down) and cfg_data; cfg_ready is always high,
// write only while no request is in flight
// requests: s_axis_tuser carries the request kind (0 load, 1 tick, 2 toggle
// pause, 3 no-op), s_axis_tdata the elapsed milliseconds of a tick
// results: one per request on m_axis, the time and flags after that request
//
// a request passes an input register, then the next-state logic, which
// updates the timer and loads the result register that drives m_axis_tvalid;
// throughput one request per cycle while m_axis_tready stays high
// reset clears the start registers, the time, the accumulator and both flags
// when m_axis_tready is low the result holds, one more request waits in the
// input register and s_axis_tready drops until the result is taken
module hms_up_down_timer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // elapsed_ms[9:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hours_now, minutes_now, seconds_now,
                                        // paused_now, finished_now, zero pad
);
    import hmsudt_pkg::*;

    cfg_t         cfg;
    timer_state_t state_reg;
    timer_state_t state_next;
    logic         in_valid_reg;
    logic         in_valid_next;
    req_t         in_req_reg;
    logic [9:0]   in_ms_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [23:0]  out_data_reg;
    logic         advance;
    logic         s_fire;

    assign cfg_ready = 1'b1;

    hmsudt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hmsudt_step u_step (
        .cfg        (cfg),
        .cur        (state_reg),
        .req        (in_req_reg),
        .elapsed_ms (in_ms_reg),
        .nxt        (state_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_req_reg <= req_t'(s_axis_tuser);
            in_ms_reg  <= s_axis_tdata[9:0];
        end
        if (advance)
        begin
            out_data_reg <= {2'b00, state_next.done, state_next.paused,
                             state_next.seconds, state_next.minutes,
                             state_next.hours};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_minsec_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.minutes <= TOP_MINSEC && state_reg.seconds <= TOP_MINSEC)
        else $error("minutes or seconds out of range");

    a_milli_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.milli} < MS_PER_SECOND)
        else $error("millisecond accumulator reached one second");

    a_done_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.done |-> (state_reg.hours == 8'd0 && state_reg.minutes == 6'd0
                            && state_reg.seconds == 6'd0))
        else $error("finished with nonzero time");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("timer state changed without a transaction");

endmodule

/* sim/hms_up_down_timer_core_tb.sv */
module hms_up_down_timer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hmsudt_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS  = 120;

    typedef struct {
        req_t       kind;
        logic [9:0] ms;
    } timer_request_t;

    typedef struct {
        logic [7:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       paused;
        logic       finished;
    } clock_reading_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // elapsed_ms[9:0], zero pad
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // hours_now, minutes_now, seconds_now,
                                      // paused_now, finished_now, zero pad

    timer_request_t request_queue[$];
    clock_reading_t expected_readings[$];
    timer_request_t staged_req;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // predicted timer state and start registers
    logic [7:0]  cfg_hours = '0;
    logic [5:0]  cfg_minutes = '0;
    logic [5:0]  cfg_seconds = '0;
    logic        cfg_down = 1'b0;
    logic [7:0]  hrs = '0;
    logic [5:0]  mins = '0;
    logic [5:0]  secs = '0;
    int unsigned milli = 0;
    logic        paused = 1'b0;
    logic        done = 1'b0;

    hms_up_down_timer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [5:0] limit_minsec(logic [5:0] v);
        return (v > 6'd59) ? 6'd59 : v;
    endfunction

    function automatic void step_one_second();
        if (cfg_down)
        begin
            if (secs != 6'd0)
                secs = secs - 6'd1;
            else if (mins != 6'd0)
            begin
                mins = mins - 6'd1;
                secs = 6'd59;
            end
            else if (hrs != 8'd0)
            begin
                hrs = hrs - 8'd1;
                mins = 6'd59;
                secs = 6'd59;
            end
            if (hrs == 8'd0 && mins == 6'd0 && secs == 6'd0)
                done = 1'b1;
        end
        else
        begin
            secs = secs + 6'd1;
            if (secs >= 6'd60)
            begin
                secs = 6'd0;
                mins = mins + 6'd1;
            end
            if (mins >= 6'd60)
            begin
                mins = 6'd0;
                hrs = hrs + 8'd1;
            end
            if (hrs >= 8'd24)
                hrs = 8'd0;
        end
    endfunction

    function automatic void advance_clock(req_t kind, logic [9:0] ms);
        clock_reading_t reading;
        int unsigned add_ms;
        case (kind)
            REQ_LOAD:
            begin
                hrs = cfg_hours;
                mins = limit_minsec(cfg_minutes);
                secs = limit_minsec(cfg_seconds);
                milli = 0;
                paused = 1'b0;
                done = 1'b0;
            end
            REQ_TICK:
            begin
                if (!paused && !done)
                begin
                    add_ms = (ms > 10'd999) ? 999 : ms;
                    milli = milli + add_ms;
                    if (milli >= 1000)
                    begin
                        milli = milli - 1000;
                        step_one_second();
                    end
                end
            end
            REQ_PAUSE:
                paused = ~paused;
            default:
                ;
        endcase
        reading.hours = hrs;
        reading.minutes = mins;
        reading.seconds = secs;
        reading.paused = paused;
        reading.finished = done;
        expected_readings.push_back(reading);
    endfunction

    function automatic void check_reading(logic [23:0] data);
        clock_reading_t exp_r;
        if (expected_readings.size() == 0)
        begin
            $error("result transaction with no request pending: %h", data);
            error_count++;
            return;
        end
        exp_r = expected_readings.pop_front();
        if (data[7:0] !== exp_r.hours)
        begin
            $error("hours_now: expected %0d, got %0d", exp_r.hours, data[7:0]);
            error_count++;
        end
        if (data[13:8] !== exp_r.minutes)
        begin
            $error("minutes_now: expected %0d, got %0d", exp_r.minutes, data[13:8]);
            error_count++;
        end
        if (data[19:14] !== exp_r.seconds)
        begin
            $error("seconds_now: expected %0d, got %0d", exp_r.seconds, data[19:14]);
            error_count++;
        end
        if (data[20] !== exp_r.paused)
        begin
            $error("paused_now: expected %0d, got %0d", exp_r.paused, data[20]);
            error_count++;
        end
        if (data[21] !== exp_r.finished)
        begin
            $error("finished_now: expected %0d, got %0d", exp_r.finished, data[21]);
            error_count++;
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_clock(req_t'(s_axis_tuser), s_axis_tdata[9:0]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    staged_req = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= staged_req.kind;
                    s_axis_tdata <= {6'd0, staged_req.ms};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_reading(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_START_HOURS:   cfg_hours = val;
            CFG_START_MINUTES: cfg_minutes = val[5:0];
            CFG_START_SECONDS: cfg_seconds = val[5:0];
            CFG_COUNT_DOWN:    cfg_down = val[0];
            default:           ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_start(logic [7:0] h, logic [5:0] m, logic [5:0] s, logic down);
        write_reg(CFG_START_HOURS, h);
        write_reg(CFG_START_MINUTES, {2'd0, m});
        write_reg(CFG_START_SECONDS, {2'd0, s});
        write_reg(CFG_COUNT_DOWN, {7'd0, down});
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || s_axis_tvalid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_request(req_t kind, int unsigned ms);
        timer_request_t r;
        r.kind = kind;
        r.ms = ms[9:0];
        request_queue.push_back(r);
    endfunction

    function automatic void set_idling(int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endfunction

    function automatic logic [7:0] pick_hours();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd23;
            3: return 8'($urandom_range(3));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [5:0] pick_minsec();
        case ($urandom_range(3))
            0: return 6'd0;
            1: return 6'd59;
            2: return 6'($urandom_range(2));
            default: return 6'($urandom_range(63));
        endcase
    endfunction

    function automatic int unsigned pick_ms();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(999, 400);
        else if (roll < 90)
            return $urandom_range(399);
        return $urandom_range(1023, 1000);
    endfunction

    function automatic void queue_random_phase();
        int unsigned roll;
        if ($urandom_range(3) != 0)
            queue_request(REQ_LOAD, $urandom_range(1023));
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 82)
                queue_request(REQ_TICK, pick_ms());
            else if (roll < 88)
                queue_request(REQ_PAUSE, $urandom_range(1023));
            else if (roll < 94)
                queue_request(REQ_LOAD, $urandom_range(1023));
            else
                queue_request(REQ_NONE, $urandom_range(1023));
        end
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero start counting down, finished and pause behavior
        write_start(8'd0, 6'd0, 6'd0, 1'b1);
        queue_request(REQ_NONE, 1023);
        queue_request(REQ_LOAD, 0);
        queue_request(REQ_TICK, 999);
        queue_request(REQ_TICK, 1);
        queue_request(REQ_TICK, 1023);
        queue_request(REQ_PAUSE, 0);
        queue_request(REQ_PAUSE, 0);
        queue_request(REQ_LOAD, 0);
        wait_drained();

        // start values out of range, counting up
        write_start(8'd255, 6'd63, 6'd63, 1'b0);
        queue_request(REQ_LOAD, 0);
        queue_request(REQ_TICK, 1023);
        queue_request(REQ_TICK, 1);
        queue_request(REQ_PAUSE, 0);
        queue_request(REQ_TICK, 999);
        queue_request(REQ_PAUSE, 0);
        queue_request(REQ_TICK, 0);
        queue_request(REQ_TICK, 1000);
        wait_drained();

        // hour borrow, then direction flipped without a load
        write_start(8'd1, 6'd0, 6'd0, 1'b1);
        queue_request(REQ_LOAD, 0);
        queue_request(REQ_TICK, 999);
        queue_request(REQ_TICK, 512);
        wait_drained();
        write_reg(CFG_COUNT_DOWN, 8'd0);
        queue_request(REQ_TICK, 500);
        wait_drained();

        // 24-hour wrap
        write_start(8'd23, 6'd59, 6'd59, 1'b0);
        queue_request(REQ_LOAD, 0);
        queue_request(REQ_TICK, 999);
        queue_request(REQ_TICK, 999);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idling(phase % 4);
            if ($urandom_range(3) == 0)
                write_reg(CFG_COUNT_DOWN, {7'd0, 1'($urandom_range(1))});
            else
                write_start(pick_hours(), pick_minsec(), pick_minsec(),
                            1'($urandom_range(1)));
            queue_random_phase();
            wait_drained();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/hmsudt_pkg.sv
hdl/hmsudt_cfg_regs.sv
hdl/hmsudt_step.sv
hdl/hms_up_down_timer_core.sv
sim/hms_up_down_timer_core_tb.sv
